// File: design/printf_integer_field_formatter_defines.svh
// Assertion macros shared by the formatter RTL.
// Depends on: signals named clk and rst_n in the module that uses them.
`ifndef PRINTF_INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define PRINTF_INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PIFMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PIFMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pifmt_pkg.sv
// Shared types, constants and helpers for the printf field formatter.
// Depends on: nothing.
package pifmt_pkg;

    // Field limits
    localparam int unsigned MAX_FIELD = 48;
    localparam int unsigned FW        = 6;   // width of width/precision fields
    localparam int unsigned CNT_W     = 7;   // holds a full conversion length
    localparam int unsigned ND_W      = 5;   // digit count, up to 16
    localparam int unsigned DIG_MAX   = 16;
    localparam int unsigned QDEPTH    = 2;   // power of two
    localparam int unsigned QA_W      = $clog2(QDEPTH);

    // Reciprocal of ten for 32-bit operands, used with a right shift of 35
    localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SH  = 35;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // Request action codes
    typedef enum logic [2:0] {
        ACT_SDEC   = 3'd0,
        ACT_UDEC   = 3'd1,
        ACT_HEX_LO = 3'd2,
        ACT_HEX_UP = 3'd3,
        ACT_PTR    = 3'd4,
        ACT_CHAR   = 3'd5,
        ACT_PCT    = 3'd6
    } action_t;

    // Work kinds handed from the front to the back
    typedef enum logic [2:0] {
        K_SDEC,
        K_UDEC,
        K_HEX,
        K_PTR,
        K_CHAR
    } kind_t;

    // Classified conversion command
    typedef struct packed {
        kind_t            kind;
        logic             neg;
        logic             upper;
        logic             zero_fill;
        logic             left_just;
        logic             has_precision;
        logic [FW-1:0]    width;
        logic [FW-1:0]    prec;
        logic [63:0]      mag;
    } cmd_t;

    // Map one digit to its ASCII character
    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10)
            begin
                return CH_ZERO + {4'd0, d};
            end
            return base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// File: design/pifmt_in_if.sv
// Request channel interface: one parsed conversion per request.
// Depends on: nothing.
interface pifmt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        zero_fill;
    logic        left_just;
    logic        has_precision;
    logic [5:0]  field_width;
    logic [5:0]  precision_digits;
    logic [63:0] value;

    modport source (
        output valid, action, zero_fill, left_just, has_precision,
               field_width, precision_digits, value,
        input  ready
    );

    modport sink (
        input  valid, action, zero_fill, left_just, has_precision,
               field_width, precision_digits, value,
        output ready
    );
endinterface

// File: design/pifmt_out_if.sv
// Character channel interface: one output byte per request.
// Depends on: nothing.
interface pifmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (
        output valid, out_char, last,
        input  ready
    );

    modport sink (
        input  valid, out_char, last,
        output ready
    );
endinterface

// File: design/pifmt_queue.sv
// Short command queue between the classifying front and the formatting back.
// Depends on: pifmt_pkg.
module pifmt_queue
    import pifmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t            entry_reg [QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QA_W:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    // Handshake on both sides
    assign push_ready = (count_reg != (QA_W + 1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? QA_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QA_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/pifmt_front.sv
// Front end: accepts requests, classifies the action and clamps the fields.
// Depends on: pifmt_pkg, pifmt_in_if.
module pifmt_front
    import pifmt_pkg::*;
(
    pifmt_in_if.sink fmt_in,
    output logic     push_valid,
    input  logic     push_ready,
    output cmd_t     push_data
);

    logic          known_act;
    logic [31:0]   v32;
    logic [FW-1:0] width_sat;
    logic [FW-1:0] prec_sat;

    assign v32 = fmt_in.value[31:0];

    // Clamp width and precision to the field limit
    assign width_sat = (fmt_in.field_width > FW'(MAX_FIELD)) ? FW'(MAX_FIELD)
                                                             : fmt_in.field_width;
    assign prec_sat  = (fmt_in.precision_digits > FW'(MAX_FIELD)) ? FW'(MAX_FIELD)
                                                                  : fmt_in.precision_digits;

    // Classify the request and prepare the magnitude
    always_comb
    begin
        push_data               = '0;
        known_act               = 1'b1;
        push_data.zero_fill     = fmt_in.zero_fill;
        push_data.left_just     = fmt_in.left_just;
        push_data.has_precision = fmt_in.has_precision;
        push_data.width         = width_sat;
        push_data.prec          = prec_sat;
        case (action_t'(fmt_in.action))
            ACT_SDEC:
            begin
                push_data.kind = K_SDEC;
                push_data.neg  = v32[31];
                push_data.mag  = {32'd0, (v32[31] ? (32'd0 - v32) : v32)};
            end
            ACT_UDEC:
            begin
                push_data.kind = K_UDEC;
                push_data.mag  = {32'd0, v32};
            end
            ACT_HEX_LO:
            begin
                push_data.kind = K_HEX;
                push_data.mag  = {32'd0, v32};
            end
            ACT_HEX_UP:
            begin
                push_data.kind  = K_HEX;
                push_data.upper = 1'b1;
                push_data.mag   = {32'd0, v32};
            end
            ACT_PTR:
            begin
                push_data.kind = K_PTR;
                push_data.mag  = fmt_in.value;
            end
            ACT_CHAR:
            begin
                push_data.kind = K_CHAR;
                push_data.mag  = {56'd0, fmt_in.value[7:0]};
            end
            ACT_PCT:
            begin
                push_data.kind = K_CHAR;
                push_data.mag  = {56'd0, CH_PCT};
            end
            default:
            begin
                // Drop requests with no meaning
                known_act = 1'b0;
            end
        endcase
    end

    assign push_valid   = fmt_in.valid && known_act;
    assign fmt_in.ready = push_ready;

endmodule

// File: design/pifmt_back.sv
// Back end: generates digits, sizes padding and emits one character per request.
// Depends on: pifmt_pkg, pifmt_out_if, printf_integer_field_formatter_defines.svh.
`include "printf_integer_field_formatter_defines.svh"

module pifmt_back
    import pifmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  cmd_t         q_data,
    pifmt_out_if.source  fmt_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGITS,
        S_CALC,
        S_EMIT
    } state_t;

    state_t           state_reg;
    kind_t            kind_reg;
    logic             neg_reg;
    logic             upper_reg;
    logic             zp_reg;
    logic             la_reg;
    logic             hp_reg;
    logic [FW-1:0]    width_reg;
    logic [FW-1:0]    prec_reg;
    logic [63:0]      work_reg;
    logic [63:0]      dig_reg;
    logic [ND_W-1:0]  nd_reg;
    logic [CNT_W-1:0] lead_reg;
    logic [7:0]       lead_char_reg;
    logic [15:0]      pre_reg;
    logic [1:0]       pre_cnt_reg;
    logic [CNT_W-1:0] zero_reg;
    logic [CNT_W-1:0] trail_reg;
    logic [CNT_W-1:0] rem_reg;
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;

    logic             pop;
    logic             emit_go;
    logic             last_go;
    logic             is_dec;
    logic [31:0]      w32;
    logic [63:0]      prod;
    logic [31:0]      quot;
    logic [31:0]      q10;
    logic [31:0]      rdec;
    logic [3:0]       digit;
    logic [63:0]      work_step;

    logic [CNT_W-1:0] nd7, width7, prec7, min_d, pz, tot, ps, upad;
    logic [CNT_W-1:0] c_lead, c_zero, c_trail, c_rem;
    logic [7:0]       c_lead_char;
    logic [15:0]      c_pre;
    logic [1:0]       c_pre_cnt;

    logic [7:0]       cur_char;
    logic [CNT_W-1:0] lead_next, zero_next, trail_next;
    logic [15:0]      pre_next;
    logic [1:0]       pre_cnt_next;
    logic [63:0]      dig_next;
    logic [ND_W-1:0]  nd_next;

    assign q_ready = (state_reg == S_IDLE);
    assign pop     = q_ready && q_valid;
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || fmt_out.ready);
    assign last_go = emit_go && (rem_reg == CNT_W'(1));

    // One digit step: divide by ten through the reciprocal, or take a nibble
    assign is_dec    = (kind_reg == K_SDEC) || (kind_reg == K_UDEC);
    assign w32       = work_reg[31:0];
    assign prod      = {32'd0, w32} * {32'd0, RECIP10};
    assign quot      = {3'd0, prod[63:RECIP_SH]};
    assign q10       = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    assign rdec      = w32 - q10;
    assign digit     = is_dec ? rdec[3:0] : work_reg[3:0];
    assign work_step = is_dec ? {32'd0, quot} : {4'd0, work_reg[63:4]};

    // Size the padding once the digit count is known
    always_comb
    begin
        nd7         = CNT_W'(nd_reg);
        width7      = CNT_W'(width_reg);
        prec7       = CNT_W'(prec_reg);
        min_d       = hp_reg ? prec7 : CNT_W'(1);
        pz          = (min_d > nd7) ? (min_d - nd7) : '0;
        tot         = CNT_W'(neg_reg) + pz + nd7;
        ps          = (width7 > tot) ? (width7 - tot) : '0;
        upad        = (width7 > nd7) ? (width7 - nd7) : '0;
        c_lead      = '0;
        c_zero      = '0;
        c_trail     = '0;
        c_lead_char = CH_SPACE;
        c_pre       = '0;
        c_pre_cnt   = '0;
        case (kind_reg)
            K_SDEC, K_HEX:
            begin
                if (zp_reg && !hp_reg && !la_reg)
                begin
                    c_zero = pz + ps;
                end
                else
                begin
                    c_zero  = pz;
                    c_lead  = la_reg ? '0 : ps;
                    c_trail = la_reg ? ps : '0;
                end
                if (neg_reg)
                begin
                    c_pre     = {CH_MINUS, 8'h00};
                    c_pre_cnt = 2'd1;
                end
            end
            K_UDEC:
            begin
                c_lead      = la_reg ? '0 : upad;
                c_trail     = la_reg ? upad : '0;
                c_lead_char = zp_reg ? CH_ZERO : CH_SPACE;
            end
            K_PTR:
            begin
                c_pre     = {CH_ZERO, CH_X};
                c_pre_cnt = 2'd2;
            end
            default:
            begin
                c_pre_cnt = '0;
            end
        endcase
        c_rem = c_lead + CNT_W'(c_pre_cnt) + c_zero + nd7 + c_trail;
    end

    // Pick the next character: lead pad, prefix, zeros, digits, trail pad
    always_comb
    begin
        cur_char     = CH_SPACE;
        lead_next    = lead_reg;
        pre_next     = pre_reg;
        pre_cnt_next = pre_cnt_reg;
        zero_next    = zero_reg;
        dig_next     = dig_reg;
        nd_next      = nd_reg;
        trail_next   = trail_reg;
        if (lead_reg != '0)
        begin
            cur_char  = lead_char_reg;
            lead_next = lead_reg - 1'b1;
        end
        else if (pre_cnt_reg != '0)
        begin
            cur_char     = pre_reg[15:8];
            pre_next     = {pre_reg[7:0], 8'h00};
            pre_cnt_next = pre_cnt_reg - 1'b1;
        end
        else if (zero_reg != '0)
        begin
            cur_char  = CH_ZERO;
            zero_next = zero_reg - 1'b1;
        end
        else if (nd_reg != '0)
        begin
            cur_char = hex_char(dig_reg[3:0], upper_reg);
            dig_next = {4'd0, dig_reg[63:4]};
            nd_next  = nd_reg - 1'b1;
        end
        else
        begin
            trail_next = (trail_reg != '0) ? (trail_reg - 1'b1) : '0;
        end
    end

    // Sequencer with output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_SDEC;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            zp_reg        <= 1'b0;
            la_reg        <= 1'b0;
            hp_reg        <= 1'b0;
            width_reg     <= '0;
            prec_reg      <= '0;
            work_reg      <= '0;
            dig_reg       <= '0;
            nd_reg        <= '0;
            lead_reg      <= '0;
            lead_char_reg <= CH_SPACE;
            pre_reg       <= '0;
            pre_cnt_reg   <= '0;
            zero_reg      <= '0;
            trail_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // Drop the output once taken unless a new character replaces it
            if (fmt_out.ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        kind_reg  <= q_data.kind;
                        neg_reg   <= q_data.neg;
                        upper_reg <= q_data.upper;
                        zp_reg    <= q_data.zero_fill;
                        la_reg    <= q_data.left_just;
                        hp_reg    <= q_data.has_precision;
                        width_reg <= q_data.width;
                        prec_reg  <= q_data.prec;
                        work_reg  <= q_data.mag;
                        nd_reg    <= '0;
                        if (q_data.kind == K_CHAR)
                        begin
                            pre_reg     <= {q_data.mag[7:0], 8'h00};
                            pre_cnt_reg <= 2'd1;
                            lead_reg    <= '0;
                            zero_reg    <= '0;
                            trail_reg   <= '0;
                            rem_reg     <= CNT_W'(1);
                            state_reg   <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_DIGITS;
                        end
                    end
                end
                S_DIGITS:
                begin
                    dig_reg  <= {dig_reg[59:0], digit};
                    nd_reg   <= nd_reg + 1'b1;
                    work_reg <= work_step;
                    if (work_step == '0)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    lead_reg      <= c_lead;
                    lead_char_reg <= c_lead_char;
                    pre_reg       <= c_pre;
                    pre_cnt_reg   <= c_pre_cnt;
                    zero_reg      <= c_zero;
                    trail_reg     <= c_trail;
                    rem_reg       <= c_rem;
                    state_reg     <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= cur_char;
                        out_last_reg  <= (rem_reg == CNT_W'(1));
                        lead_reg      <= lead_next;
                        pre_reg       <= pre_next;
                        pre_cnt_reg   <= pre_cnt_next;
                        zero_reg      <= zero_next;
                        dig_reg       <= dig_next;
                        nd_reg        <= nd_next;
                        trail_reg     <= trail_next;
                        rem_reg       <= rem_reg - 1'b1;
                        if (rem_reg == CNT_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign fmt_out.valid    = out_valid_reg;
    assign fmt_out.out_char = out_char_reg;
    assign fmt_out.last     = out_last_reg;

    // Consistency checks on the sequencer
    `PIFMT_ASSERT_SAME(a_emit_has_work, state_reg == S_EMIT, rem_reg != '0, "emit with none left")
    `PIFMT_ASSERT_NEXT(a_last_to_idle, last_go, state_reg == S_IDLE && out_last_reg, "last not ended")
    `PIFMT_ASSERT_SAME(a_digit_bound, state_reg == S_DIGITS, nd_reg < ND_W'(DIG_MAX), "digit overflow")
    `PIFMT_ASSERT_NEXT(a_pop_leaves_idle, pop, state_reg != S_IDLE, "popped command not started")

endmodule

// File: design/printf_integer_field_formatter.sv
// printf integer field formatter: turns one parsed conversion into characters.
// Channels: fmt_in (sink) takes one conversion per request: action, zero_fill,
//   left_just, has_precision, field_width, precision_digits and value.
//   fmt_out (source) gives one character per request, last set on the final one.
// Action seven is accepted and dropped with no output.
// A two-entry command queue sits between the classifying front and the back,
// so up to two conversions are taken while an earlier one is still printed.
// The back works on one conversion at a time: it takes the command, makes one
// digit per step (up to 10 for decimal, 8 for hex, 16 for a pointer; the
// divide-by-ten step uses a single 32x32 multiplier), sizes the padding, then
// emits one character per step (up to 49). A char or percent item skips the
// digit and sizing steps.
// A stalled receiver holds the output register and the back waits on it;
// the queue keeps taking requests until full.
// Reset empties the queue and returns the back to idle; nothing else to clear.
// Depends on: pifmt_pkg, pifmt_in_if, pifmt_out_if, pifmt_front, pifmt_queue,
//   pifmt_back.
module printf_integer_field_formatter
    import pifmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pifmt_in_if.sink     fmt_in,
    pifmt_out_if.source  fmt_out
);

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    // Classify requests
    pifmt_front u_front (
        .fmt_in     (fmt_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple front and back
    pifmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Generate and emit characters
    pifmt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .fmt_out (fmt_out)
    );

endmodule

// File: tb/sv/printf_integer_field_formatter_test.sv
// Self-checking bench for the printf integer field formatter: drives parsed conversions,
// predicts every output character and compares each one with the oldest expected.
// Depends on: pifmt_pkg, pifmt_in_if, pifmt_out_if, printf_integer_field_formatter.
module printf_integer_field_formatter_test;
    import pifmt_pkg::*;

    // Action code with no meaning; the block drops it
    localparam logic [2:0] ACT_NONE = 3'd7;
    localparam int unsigned DRAIN_CYCLES = 64;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [2:0]  action;
        logic        zero_fill;
        logic        left_just;
        logic        has_precision;
        logic [5:0]  field_width;
        logic [5:0]  precision_digits;
        logic [63:0] value;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    // Expected-character store with its own formatter
    class char_scoreboard;
        char_beat_t expected_chars[$];
        int         errors;
        int         checked;

        task report(input string msg);
            if (errors < 40)
            begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function int pending();
            return expected_chars.size();
        endfunction

        // Build the digit string, most significant first
        function char_q_t digits_of(input logic [63:0] v, input bit hex, input bit upper);
            char_q_t    digs;
            logic [3:0] d;
            digs = {};
            do
            begin
                if (hex)
                begin
                    d = v[3:0];
                    v = v >> 4;
                end
                else
                begin
                    d = 4'(v % 64'd10);
                    v = v / 64'd10;
                end
                if (d < 4'd10)
                begin
                    digs.push_front(CH_ZERO + {4'd0, d});
                end
                else
                begin
                    digs.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10);
                end
            end
            while (v != 64'd0);
            return digs;
        endfunction

        // Format one accepted request into its expected characters
        function void note_request(input conv_req_t r);
            char_q_t     chars;
            char_q_t     digs;
            int          width;
            int          prec;
            int          digit_floor;
            int          zero_cnt;
            int          space_cnt;
            int          total;
            bit          neg;
            logic [31:0] v32;
            chars = {};
            neg   = 1'b0;
            width = (r.field_width > MAX_FIELD) ? MAX_FIELD : r.field_width;
            prec  = (r.precision_digits > MAX_FIELD) ? MAX_FIELD : r.precision_digits;
            case (r.action)
                ACT_SDEC, ACT_HEX_LO, ACT_HEX_UP:
                begin
                    v32 = r.value[31:0];
                    if (r.action == ACT_SDEC)
                    begin
                        if (v32[31])
                        begin
                            neg = 1'b1;
                            v32 = -v32;
                        end
                        digs = digits_of({32'd0, v32}, 1'b0, 1'b0);
                    end
                    else
                    begin
                        digs = digits_of({32'd0, v32}, 1'b1, r.action == ACT_HEX_UP);
                    end
                    digit_floor = r.has_precision ? prec : 1;
                    zero_cnt    = (digit_floor > digs.size()) ? digit_floor - digs.size() : 0;
                    total       = int'(neg) + zero_cnt + digs.size();
                    space_cnt   = (width > total) ? width - total : 0;
                    // zeros take the place of the spaces only without precision or minus
                    if (r.zero_fill && !r.has_precision && !r.left_just)
                    begin
                        zero_cnt += space_cnt;
                        space_cnt = 0;
                    end
                    if (!r.left_just)
                    begin
                        repeat (space_cnt) chars.push_back(CH_SPACE);
                    end
                    if (neg)
                    begin
                        chars.push_back(CH_MINUS);
                    end
                    repeat (zero_cnt) chars.push_back(CH_ZERO);
                    chars = {chars, digs};
                    if (r.left_just)
                    begin
                        repeat (space_cnt) chars.push_back(CH_SPACE);
                    end
                end
                ACT_UDEC:
                begin
                    digs = digits_of({32'd0, r.value[31:0]}, 1'b0, 1'b0);
                    space_cnt = (width > digs.size()) ? width - digs.size() : 0;
                    if (!r.left_just)
                    begin
                        repeat (space_cnt) chars.push_back(r.zero_fill ? CH_ZERO : CH_SPACE);
                    end
                    chars = {chars, digs};
                    if (r.left_just)
                    begin
                        repeat (space_cnt) chars.push_back(CH_SPACE);
                    end
                end
                ACT_PTR:
                begin
                    chars.push_back(CH_ZERO);
                    chars.push_back(CH_X);
                    chars = {chars, digits_of(r.value, 1'b1, 1'b0)};
                end
                ACT_CHAR:
                begin
                    chars.push_back(r.value[7:0]);
                end
                ACT_PCT:
                begin
                    chars.push_back(CH_PCT);
                end
                default:
                begin
                end
            endcase
            foreach (chars[i])
            begin
                expected_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
            end
        endfunction

        // Compare one output character with the oldest expected one
        task check_char(input logic [7:0] ch, input logic last);
            char_beat_t e;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            e = expected_chars.pop_front();
            checked++;
            if (ch !== e.ch)
            begin
                report($sformatf("out_char 0x%02h, want 0x%02h", ch, e.ch));
            end
            if (last !== e.last)
            begin
                report($sformatf("last %0b, want %0b (char 0x%02h)", last, e.last, e.ch));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    pifmt_in_if  in_ch();
    pifmt_out_if out_ch();

    char_scoreboard sb = new;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int requests_sent = 0;

    printf_integer_field_formatter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt_in  (in_ch),
        .fmt_out (out_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Output side: hold off while a long stall is counting, else stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every accepted character
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sb.check_char(out_ch.out_char, out_ch.last);
        end
    end

    function automatic conv_req_t mk(input logic [2:0] action, input logic zp, input logic la,
                                     input logic hp, input logic [5:0] w, input logic [5:0] p,
                                     input logic [63:0] v);
        conv_req_t r;
        r.action           = action;
        r.zero_fill        = zp;
        r.left_just        = la;
        r.has_precision    = hp;
        r.field_width      = w;
        r.precision_digits = p;
        r.value            = v;
        return r;
    endfunction

    // Pick a size: mostly short fields, sometimes past the limit
    function automatic logic [5:0] random_size();
        if ($urandom_range(0, 99) < 12)
        begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(0, 20));
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)      r.action = ACT_SDEC;
        else if (pick < 40) r.action = ACT_UDEC;
        else if (pick < 56) r.action = ACT_HEX_LO;
        else if (pick < 70) r.action = ACT_HEX_UP;
        else if (pick < 80) r.action = ACT_PTR;
        else if (pick < 88) r.action = ACT_CHAR;
        else if (pick < 95) r.action = ACT_PCT;
        else                r.action = ACT_NONE;
        r.zero_fill        = 1'($urandom_range(0, 1));
        r.left_just        = 1'($urandom_range(0, 1));
        r.has_precision    = 1'($urandom_range(0, 1));
        r.field_width      = random_size();
        r.precision_digits = random_size();
        case ($urandom_range(0, 5))
            0:       r.value = {$urandom, 32'd0};
            1:       r.value = {$urandom, 32'($urandom_range(0, 20))};
            2:       r.value = {$urandom, 32'h8000_0000 | 32'($urandom_range(0, 3))};
            3:       r.value = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
            default: r.value = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // Offer one request, with an optional idle gap first; return at its accept edge
    task automatic send_request(input conv_req_t r);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.action           <= r.action;
        in_ch.zero_fill        <= r.zero_fill;
        in_ch.left_just        <= r.left_just;
        in_ch.has_precision    <= r.has_precision;
        in_ch.field_width      <= r.field_width;
        in_ch.precision_digits <= r.precision_digits;
        in_ch.value            <= r.value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Drop valid and wait until every expected character has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.action           = ACT_SDEC;
        in_ch.zero_fill        = 1'b0;
        in_ch.left_just        = 1'b0;
        in_ch.has_precision    = 1'b0;
        in_ch.field_width      = '0;
        in_ch.precision_digits = '0;
        in_ch.value            = '0;
        out_ch.ready           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every action, saturation and the zero cases
        send_request(mk(ACT_SDEC,   1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  64'd0));
        send_request(mk(ACT_SDEC,   1'b0, 1'b0, 1'b1, 6'd0,  6'd0,  64'd0));
        send_request(mk(ACT_SDEC,   1'b1, 1'b0, 1'b0, 6'd48, 6'd0,  64'h0000_0000_8000_0000));
        send_request(mk(ACT_SDEC,   1'b0, 1'b0, 1'b1, 6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_SDEC,   1'b1, 1'b1, 1'b0, 6'd63, 6'd0,  64'hFFFF_FFFF_7FFF_FFFF));
        send_request(mk(ACT_SDEC,   1'b1, 1'b0, 1'b1, 6'd30, 6'd5,  64'h0000_0000_FFFF_FF85));
        send_request(mk(ACT_SDEC,   1'b0, 1'b0, 1'b1, 6'd49, 6'd47, 64'd12345));
        send_request(mk(ACT_UDEC,   1'b1, 1'b0, 1'b1, 6'd20, 6'd40, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_UDEC,   1'b1, 1'b1, 1'b0, 6'd15, 6'd0,  64'hABCD_0000_0000_007B));
        send_request(mk(ACT_UDEC,   1'b0, 1'b0, 1'b0, 6'd63, 6'd0,  64'd0));
        send_request(mk(ACT_HEX_LO, 1'b0, 1'b0, 1'b1, 6'd0,  6'd12, 64'h0000_0000_DEAD_BEEF));
        send_request(mk(ACT_HEX_LO, 1'b0, 1'b0, 1'b1, 6'd4,  6'd0,  64'd0));
        send_request(mk(ACT_HEX_UP, 1'b1, 1'b0, 1'b0, 6'd16, 6'd0,  64'h5555_5555_ABCD_EF01));
        send_request(mk(ACT_HEX_UP, 1'b1, 1'b1, 1'b0, 6'd10, 6'd0,  64'h0000_0000_0000_00FA));
        send_request(mk(ACT_HEX_UP, 1'b0, 1'b1, 1'b1, 6'd48, 6'd48, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_PTR,    1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  64'd0));
        send_request(mk(ACT_PTR,    1'b1, 1'b1, 1'b1, 6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_PTR,    1'b0, 1'b0, 1'b0, 6'd20, 6'd0,  64'h0000_0001_0000_0000));
        send_request(mk(ACT_CHAR,   1'b1, 1'b1, 1'b1, 6'd63, 6'd63, 64'h1234_5678_9ABC_DEFF));
        send_request(mk(ACT_CHAR,   1'b0, 1'b0, 1'b0, 6'd5,  6'd0,  64'd0));
        send_request(mk(ACT_PCT,    1'b1, 1'b0, 1'b1, 6'd40, 6'd9,  64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_NONE,   1'b1, 1'b1, 1'b1, 6'd48, 6'd48, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk(ACT_SDEC,   1'b0, 1'b1, 1'b0, 6'd12, 6'd0,  64'h0000_0000_FFFF_FFFF));
        wait_drained();

        // Random: free flow, sender idle, receiver stall, both
        run_phase(0,  0,  120);
        run_phase(63, 0,  120);
        run_phase(0,  63, 120);
        run_phase(16, 16, 120);
        wait_drained();

        // Hold the output off long enough to fill the block and stall its input
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left    <= 400;
        repeat (12) send_request(random_request());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d characters never came out", sb.pending()));
        end
        $display("Covered %0d conversions, %0d characters: all actions, flag mixes, limits,",
                 requests_sent, sb.checked);
        $display("idle and stall mixes on both sides and a long output hold-off.");
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
